>>> design/line_number_or_text_classifier_core_defines.svh
// Assertion macros used by the line classifier emitter (lnc_back).
`ifndef LINE_NUMBER_OR_TEXT_CLASSIFIER_CORE_DEFINES_SVH
`define LINE_NUMBER_OR_TEXT_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lnc_pkg.sv
// Types and constants shared by the line classifier modules.
package lnc_pkg;

    localparam int ACC_W      = 31;
    localparam int CNT_W      = 6;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = 1;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_POINT = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [ACC_W-1:0] ACC_TENTH  = 31'd214748364;
    localparam logic [3:0]       DIGIT_LIM  = 4'd7;
    localparam logic [7:0]       PLACES_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_EMPTY  = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_TEXT   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_EMPTY  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_SEND = 2'd2
    } t_back_state;

    // One finished line, handed from the classifier to the emitter.
    typedef struct packed {
        t_kind              kind;
        logic [ACC_W-1:0]   int_part;
        logic [ACC_W-1:0]   frac_value;
        logic [7:0]         frac_places;
        logic               minus_sign;
        logic [CNT_W-1:0]   cnt;
    } t_job;

    // Line buffer write port.
    typedef struct packed {
        logic               en;
        logic [CNT_W-1:0]   addr;
        logic [7:0]         data;
    } t_store_wr;

endpackage

>>> design/lnc_front.sv
// Character classifier: number accumulation, mode tracking, line buffer writes.
module lnc_front #(
    parameter int LINE_CHARS = 40
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char,
    input  logic               i_fifo_full,
    input  logic               i_text_done,
    output logic               o_push,
    output lnc_pkg::t_job      o_job,
    output lnc_pkg::t_store_wr o_wr
);
    import lnc_pkg::*;

    localparam int DEPTH = LINE_CHARS - 1;
    localparam int CW    = $clog2(LINE_CHARS);

    t_mode            r_mode,  n_mode;
    logic [ACC_W-1:0] r_int,   n_int;
    logic [ACC_W-1:0] r_frac,  n_frac;
    logic             r_point, n_point;
    logic [7:0]       r_places, n_places;
    logic             r_minus, n_minus;
    logic [CW-1:0]    r_fill,  n_fill;
    logic             r_pend,  n_pend;

    logic             accept;
    logic             eol;
    logic             digit;
    logic [3:0]       dval;
    logic [ACC_W-1:0] acc_sel;
    logic             acc_ovf;
    logic [33:0]      acc_x10;
    logic [ACC_W-1:0] acc_next;

    // a text job owns the line buffer until its last character is read out
    assign o_ready = !i_fifo_full && !r_pend;
    assign accept  = i_valid && o_ready;
    assign eol     = (i_char == CH_CR) || (i_char == CH_LF);
    assign dval    = 4'(i_char - CH_ZERO);

    always_comb begin
        digit = i_char inside {[CH_ZERO:CH_NINE]};
    end

    // one shared multiply-by-ten path for whichever accumulator is active
    assign acc_sel  = r_point ? r_frac : r_int;
    assign acc_ovf  = (acc_sel > ACC_TENTH) || ((acc_sel == ACC_TENTH) && (dval > DIGIT_LIM));
    assign acc_x10  = {acc_sel, 3'b000} + {2'b00, acc_sel, 1'b0} + 34'(dval);
    assign acc_next = acc_x10[ACC_W-1:0];

    always_comb begin
        n_mode   = r_mode;
        n_int    = r_int;
        n_frac   = r_frac;
        n_point  = r_point;
        n_places = r_places;
        n_minus  = r_minus;
        n_fill   = r_fill;
        n_pend   = r_pend;
        o_push   = 1'b0;
        o_job    = '0;
        o_wr     = '0;
        if (i_text_done) begin
            n_pend = 1'b0;
        end
        if (accept) begin
            if (!eol) begin
                if (r_fill < CW'(DEPTH)) begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = CNT_W'(r_fill);
                    o_wr.data = i_char;
                    n_fill    = CW'(r_fill + 1'b1);
                end
                case (r_mode)
                    MODE_NUMBER: begin
                        if (digit) begin
                            if (acc_ovf) begin
                                n_mode = MODE_TEXT;
                            end else if (r_point) begin
                                n_frac = acc_next;
                            end else begin
                                n_int = acc_next;
                            end
                            if (r_point && (r_places != PLACES_MAX)) begin
                                n_places = r_places + 8'd1;
                            end
                        end else if ((i_char == CH_POINT) && !r_point) begin
                            n_point = 1'b1;
                        end else begin
                            n_mode = MODE_TEXT;
                        end
                    end
                    MODE_EMPTY: begin
                        if (digit) begin
                            n_mode = MODE_NUMBER;
                            n_int  = ACC_W'(dval);
                        end else if (i_char == CH_MINUS) begin
                            n_mode  = MODE_NUMBER;
                            n_minus = 1'b1;
                        end else begin
                            n_mode = MODE_TEXT;
                        end
                    end
                    default: ;
                endcase
            end else begin
                o_push = 1'b1;
                if (r_mode == MODE_NUMBER) begin
                    o_job.kind        = KIND_NUMBER;
                    o_job.int_part    = r_int;
                    o_job.frac_value  = r_frac;
                    o_job.frac_places = r_places;
                    o_job.minus_sign  = r_minus;
                end else if ((r_mode != MODE_EMPTY) && (r_fill != '0)) begin
                    o_job.kind = KIND_TEXT;
                    o_job.cnt  = CNT_W'(r_fill);
                    n_pend     = 1'b1;
                end else begin
                    o_job.kind = KIND_EMPTY;
                end
                n_mode   = MODE_EMPTY;
                n_int    = '0;
                n_frac   = '0;
                n_point  = 1'b0;
                n_places = '0;
                n_minus  = 1'b0;
                n_fill   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_EMPTY;
            r_int    <= '0;
            r_frac   <= '0;
            r_point  <= 1'b0;
            r_places <= '0;
            r_minus  <= 1'b0;
            r_fill   <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_int    <= n_int;
            r_frac   <= n_frac;
            r_point  <= n_point;
            r_places <= n_places;
            r_minus  <= n_minus;
            r_fill   <= n_fill;
            r_pend   <= n_pend;
        end
    end

endmodule

>>> design/lnc_fifo.sv
// Two-entry job queue between the classifier and the emitter.
module lnc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lnc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output lnc_pkg::t_job o_job
);
    import lnc_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, n_wptr;
    logic [FIFO_AW-1:0] r_rptr, n_rptr;
    logic [FIFO_AW:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = do_push ? FIFO_AW'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_pop  ? FIFO_AW'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = (FIFO_AW + 1)'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = (FIFO_AW + 1)'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

>>> design/lnc_back.sv
// Result emitter: line buffer memory, text read-out sequencer, output register.
`include "line_number_or_text_classifier_core_defines.svh"

module lnc_back #(
    parameter int LINE_CHARS = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lnc_pkg::t_store_wr     i_wr,
    input  logic                   i_job_valid,
    input  lnc_pkg::t_job          i_job,
    output logic                   o_pop,
    output logic                   o_text_done,
    output logic                   o_valid,
    input  logic                   i_ready,
    output lnc_pkg::t_kind         o_kind,
    output logic [lnc_pkg::ACC_W-1:0] o_int_part,
    output logic [lnc_pkg::ACC_W-1:0] o_frac_value,
    output logic [7:0]             o_frac_places,
    output logic                   o_minus_sign,
    output logic [7:0]             o_text_char,
    output logic                   o_last
);
    import lnc_pkg::*;

    localparam int DEPTH = LINE_CHARS - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]       r_line [DEPTH];
    logic [7:0]       r_rd_data;

    t_back_state      r_state, n_state;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic [CNT_W-1:0] r_cnt,   n_cnt;

    logic             r_out_valid, n_out_valid;
    t_kind            r_kind,   n_kind;
    logic [ACC_W-1:0] r_int,    n_int;
    logic [ACC_W-1:0] r_frac,   n_frac;
    logic [7:0]       r_places, n_places;
    logic             r_neg,    n_neg;
    logic [7:0]       r_char,   n_char;
    logic             r_last,   n_last;

    logic             out_free;
    logic             send_last;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_line[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        r_rd_data <= r_line[r_idx[AW-1:0]];
    end

    assign out_free  = !r_out_valid || i_ready;
    assign send_last = (CNT_W'(r_idx + 1'b1) == r_cnt);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_kind      = r_kind;
        n_int       = r_int;
        n_frac      = r_frac;
        n_places    = r_places;
        n_neg       = r_neg;
        n_char      = r_char;
        n_last      = r_last;
        o_pop       = 1'b0;
        o_text_done = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid && out_free) begin
                    o_pop = 1'b1;
                    if (i_job.kind == KIND_TEXT) begin
                        n_cnt   = i_job.cnt;
                        n_idx   = '0;
                        n_state = BK_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        n_kind      = i_job.kind;
                        n_int       = i_job.int_part;
                        n_frac      = i_job.frac_value;
                        n_places    = i_job.frac_places;
                        n_neg       = i_job.minus_sign;
                        n_char      = '0;
                        n_last      = 1'b1;
                    end
                end
            end
            BK_READ: begin
                n_state = BK_SEND;
            end
            BK_SEND: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TEXT;
                    n_int       = '0;
                    n_frac      = '0;
                    n_places    = '0;
                    n_neg       = 1'b0;
                    n_char      = r_rd_data;
                    n_last      = send_last;
                    if (send_last) begin
                        n_state     = BK_IDLE;
                        o_text_done = 1'b1;
                    end else begin
                        n_idx   = CNT_W'(r_idx + 1'b1);
                        n_state = BK_READ;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_kind   <= n_kind;
        r_int    <= n_int;
        r_frac   <= n_frac;
        r_places <= n_places;
        r_neg    <= n_neg;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_kind;
    assign o_int_part    = r_int;
    assign o_frac_value  = r_frac;
    assign o_frac_places = r_places;
    assign o_minus_sign  = r_neg;
    assign o_text_char   = r_char;
    assign o_last        = r_last;

    `LNC_ASSERT_NOW(a_idx_in_range, i_clk, i_rst_n, (r_state != BK_IDLE), (r_idx < r_cnt), "read index past text length")
    `LNC_ASSERT_NEXT(a_done_marks_last, i_clk, i_rst_n, o_text_done, (r_out_valid && r_last && (r_kind == KIND_TEXT)), "text done without final text result")
    `LNC_ASSERT_NOW(a_non_text_no_char, i_clk, i_rst_n, (r_out_valid && (r_kind != KIND_TEXT)), ((r_char == '0) && r_last), "non-text result malformed")
    `LNC_ASSERT_NOW(a_pop_when_idle, i_clk, i_rst_n, o_pop, ((r_state == BK_IDLE) && out_free), "job taken while emitter busy")

endmodule

>>> design/line_number_or_text_classifier_core.sv
// Top level of the line classifier: ASCII number / text line parser on stream ports.
// Path: a number or empty-line job passes the job queue, then the output register;
//   each text character is read from the buffer (READ state), then sent (SEND state).
// Throughput: one character per cycle while the job queue has room; after a text line
//   ends, input holds off until its last character is in the output register.
// Reset: synchronous active low; clears line state, job queue, emitter and output valid.
module line_number_or_text_classifier_core #(
    parameter int LINE_CHARS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: one received character per transaction
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_char
    // master side: one result per transaction
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // [30:0] int_part, [61:31] frac_value,
                                          // [69:62] frac_places, [70] minus_sign,
                                          // [78:71] text_char, [79] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind: 0 number, 1 text char, 2 empty
    output logic        o_m_axis_tlast    // last result of the line
);
    import lnc_pkg::*;

    t_job             job_in;
    t_job             job_head;
    t_store_wr        store_wr;
    logic             job_push;
    logic             job_pop;
    logic             job_valid;
    logic             fifo_full;
    logic             text_done;

    t_kind            res_kind;
    logic [ACC_W-1:0] res_int;
    logic [ACC_W-1:0] res_frac;
    logic [7:0]       res_places;
    logic             res_neg;
    logic [7:0]       res_char;

    // front: classifies each character and fills the line buffer; a line end
    // turns into one job in the queue
    lnc_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_char      (i_s_axis_tdata),
        .i_fifo_full (fifo_full),
        .i_text_done (text_done),
        .o_push      (job_push),
        .o_job       (job_in),
        .o_wr        (store_wr)
    );

    // short queue so number lines can be classified while results wait downstream
    lnc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (fifo_full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (job_head)
    );

    // back: turns jobs into result transactions, walking the buffer for text
    lnc_back #(
        .LINE_CHARS (LINE_CHARS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (store_wr),
        .i_job_valid   (job_valid),
        .i_job         (job_head),
        .o_pop         (job_pop),
        .o_text_done   (text_done),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_kind        (res_kind),
        .o_int_part    (res_int),
        .o_frac_value  (res_frac),
        .o_frac_places (res_places),
        .o_minus_sign  (res_neg),
        .o_text_char   (res_char),
        .o_last        (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, res_char, res_neg, res_places, res_frac, res_int};
    assign o_m_axis_tuser = res_kind;

endmodule
